// File: src/spd_pkg.sv
// ---------------------------------------------------------------------------
// spd_pkg
// Shared types, request and status codes of the slotted page directory.
// ---------------------------------------------------------------------------
package spd_pkg;

  // default page geometry
  localparam int PAGE_BYTES_DEF   = 8192;
  localparam int HEADER_BYTES_DEF = 40;
  localparam int ENTRY_BYTES_DEF  = 8;
  localparam int MAX_SLOTS_DEF    = 256;

  // byte pointer width covers the largest page, slot counts reach 256
  localparam int PTR_W = 15;
  localparam int CNT_W = 9;

  // compaction rule thresholds
  localparam int NEAR_FULL_BYTES = 100;
  localparam int WASTE_PERCENT   = 50;

  // request codes
  localparam logic [2:0] REQ_INSERT  = 3'd0;
  localparam logic [2:0] REQ_DELETE  = 3'd1;
  localparam logic [2:0] REQ_UPDATE  = 3'd2;
  localparam logic [2:0] REQ_FORWARD = 3'd3;
  localparam logic [2:0] REQ_FOLLOW  = 3'd4;
  localparam logic [2:0] REQ_COMPACT = 3'd5;
  localparam logic [2:0] REQ_QUERY   = 3'd6;

  // status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_NO_SPACE  = 3'd1;
  localparam logic [2:0] STAT_ZERO_SIZE = 3'd2;
  localparam logic [2:0] STAT_BAD_SLOT  = 3'd3;
  localparam logic [2:0] STAT_NOT_VALID = 3'd4;
  localparam logic [2:0] STAT_FORWARDED = 3'd5;
  localparam logic [2:0] STAT_TOO_LARGE = 3'd6;
  localparam logic [2:0] STAT_CHAIN     = 3'd7;

  // one directory entry, 53 bits
  typedef struct packed {
    logic [13:0] off;
    logic [12:0] len;
    logic        live;
    logic        fwd;
    logic [15:0] npage;
    logic [7:0]  nslot;
  } entry_t;

  // directory memory access for one cycle
  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    entry_t     wdata;
    logic [7:0] raddr;
  } mem_req_t;

endpackage

// File: src/spd_table.sv
// ---------------------------------------------------------------------------
// spd_table
// Slot directory memory: one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module spd_table #(
  parameter int MAX_SLOTS = spd_pkg::MAX_SLOTS_DEF
) (
  input  logic             clk,
  input  spd_pkg::mem_req_t req,
  output spd_pkg::entry_t  rdata
);

  localparam int AW = $clog2(MAX_SLOTS);

  spd_pkg::entry_t mem [MAX_SLOTS];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr[AW-1:0]];
  end

endmodule

// File: src/spd_ctrl.sv
// ---------------------------------------------------------------------------
// spd_ctrl
// Request sequencer: scans, read-modify-write of entries, chain walks and
// the page bookkeeping registers.
// ---------------------------------------------------------------------------
module spd_ctrl #(
  parameter int PAGE_BYTES   = spd_pkg::PAGE_BYTES_DEF,
  parameter int HEADER_BYTES = spd_pkg::HEADER_BYTES_DEF,
  parameter int ENTRY_BYTES  = spd_pkg::ENTRY_BYTES_DEF,
  parameter int MAX_SLOTS    = spd_pkg::MAX_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        req_type,
  input  logic [7:0]        slot,
  input  logic [12:0]       size,
  input  logic [15:0]       target_page,
  input  logic [7:0]        target_slot,
  input  logic [15:0]       own_page_id,
  input  logic [7:0]        hop_limit,
  output spd_pkg::mem_req_t mreq,
  input  spd_pkg::entry_t   rdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [7:0]        slot_out,
  output logic [15:0]       page_out,
  output logic [12:0]       offset_out,
  output logic [12:0]       length_out,
  output logic              valid_out,
  output logic              forwarded_out,
  output logic [13:0]       free_bytes,
  output logic              needs_compaction
);

  localparam int PW = spd_pkg::PTR_W;
  localparam int CW = spd_pkg::CNT_W;
  localparam logic [PW-1:0] HDR  = PW'(HEADER_BYTES);
  localparam logic [PW-1:0] PAGE = PW'(PAGE_BYTES);
  localparam logic [PW-1:0] ENT  = PW'(ENTRY_BYTES);
  localparam logic [CW-1:0] MAXS = CW'(MAX_SLOTS);
  localparam logic [PW:0]   NEAR = (PW+1)'(spd_pkg::NEAR_FULL_BYTES);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DISP = 4'd1;
  localparam logic [3:0] ST_SCAN = 4'd2;
  localparam logic [3:0] ST_INS  = 4'd3;
  localparam logic [3:0] ST_READ = 4'd4;
  localparam logic [3:0] ST_OP   = 4'd5;
  localparam logic [3:0] ST_FRD  = 4'd6;
  localparam logic [3:0] ST_FCHK = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  logic [3:0]    state;
  // latched request
  logic [2:0]    req_r;
  logic [7:0]    slot_r;
  logic [12:0]   size_r;
  logic [15:0]   tpage_r;
  logic [7:0]    tslot_r;
  // page bookkeeping
  logic [PW-1:0] data_end;
  logic [PW-1:0] dir_start;
  logic [CW-1:0] slots_used;
  logic [CW-1:0] deleted;
  logic [PW-1:0] wasted;
  // scan and walk working registers
  logic [CW-1:0] cnt;
  logic          chk;
  logic [7:0]    chk_idx;
  logic [PW-1:0] pos;
  logic          reuse;
  logic [7:0]    pick;
  logic [12:0]   old_len;
  logic [7:0]    hop;
  logic [15:0]   wpage;
  logic [7:0]    wcur;
  // result under construction
  logic [2:0]    r_status;
  logic [7:0]    r_slot;
  logic [15:0]   r_page;
  spd_pkg::entry_t r_ent;

  logic [PW-1:0] free_now;
  logic          flag;
  logic [PW-1:0] need;
  logic          ins_ok;
  spd_pkg::entry_t ins_ent;
  spd_pkg::entry_t op_ent;
  logic [2:0]    op_st;
  logic          fin_go;

  assign in_ready = (state == ST_IDLE);
  assign fin_go   = !out_valid || out_ready;

  // free space and compaction rule; waste*100/used >= 50 is 2*waste >= used
  always_comb begin
    logic [PW-1:0] used;
    logic [PW:0]   sum;
    free_now = (dir_start >= data_end) ? (dir_start - data_end) : '0;
    used     = (data_end >= HDR) ? (data_end - HDR) : '0;
    sum      = {1'b0, free_now} + {1'b0, wasted};
    flag     = 1'b0;
    if (deleted != '0) begin
      if (used != '0 && ({1'b0, wasted} * (PW+1)'(100 / spd_pkg::WASTE_PERCENT))
          >= {1'b0, used})
        flag = 1'b1;
      if ({deleted, 1'b0} >= {1'b0, slots_used})
        flag = 1'b1;
      if ({1'b0, free_now} < NEAR && sum >= NEAR)
        flag = 1'b1;
    end
  end

  // insert check and new entry
  always_comb begin
    need = reuse ? PW'(size_r) : (PW'(size_r) + ENT);
    ins_ok = !(!reuse && slots_used >= MAXS) && (free_now >= need);
    ins_ent = '0;
    ins_ent.off  = data_end[13:0];
    ins_ent.len  = size_r;
    ins_ent.live = 1'b1;
  end

  // modify step for delete, update, forward and query
  always_comb begin
    op_ent = rdata;
    op_st  = spd_pkg::STAT_OK;
    case (req_r)
      spd_pkg::REQ_DELETE: begin
        if (rdata.live) op_ent.live = 1'b0;
        else op_st = spd_pkg::STAT_NOT_VALID;
      end
      spd_pkg::REQ_UPDATE: begin
        if (!rdata.live) op_st = spd_pkg::STAT_NOT_VALID;
        else if (rdata.fwd) op_st = spd_pkg::STAT_FORWARDED;
        else if (size_r > rdata.len) op_st = spd_pkg::STAT_TOO_LARGE;
        else op_ent.len = size_r;
      end
      spd_pkg::REQ_FORWARD: begin
        if (rdata.live) begin
          op_ent.len   = '0;
          op_ent.npage = tpage_r;
          op_ent.nslot = tslot_r;
          op_ent.fwd   = 1'b1;
        end else begin
          op_st = spd_pkg::STAT_NOT_VALID;
        end
      end
      default: ;
    endcase
  end

  // memory access of the current step
  always_comb begin
    mreq = '0;
    case (state)
      ST_SCAN: begin
        mreq.raddr = cnt[7:0];
        if (req_r == spd_pkg::REQ_COMPACT && chk) begin
          mreq.we    = 1'b1;
          mreq.waddr = chk_idx;
          if (rdata.live) begin
            mreq.wdata     = rdata;
            mreq.wdata.off = pos[13:0];
          end
        end
      end
      ST_READ: mreq.raddr = slot_r;
      ST_OP: begin
        mreq.we    = 1'b1;
        mreq.waddr = slot_r;
        mreq.wdata = op_ent;
      end
      ST_INS: begin
        mreq.we    = ins_ok;
        mreq.waddr = pick;
        mreq.wdata = ins_ent;
      end
      ST_FRD: mreq.raddr = wcur;
      default: ;
    endcase
  end

  // result valid: set when a result is loaded, cleared on its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && fin_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      data_end   <= HDR;
      dir_start  <= PAGE;
      slots_used <= '0;
      deleted    <= '0;
      wasted     <= '0;
      chk        <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req_r    <= req_type;
            slot_r   <= slot;
            size_r   <= size;
            tpage_r  <= target_page;
            tslot_r  <= target_slot;
            r_status <= spd_pkg::STAT_OK;
            r_slot   <= '0;
            r_page   <= '0;
            r_ent    <= '0;
            state    <= ST_DISP;
          end
        end
        ST_DISP: begin
          cnt   <= '0;
          chk   <= 1'b0;
          pos   <= HDR;
          reuse <= 1'b0;
          state <= ST_FIN;
          case (req_r)
            spd_pkg::REQ_INSERT: begin
              if (size_r == '0) r_status <= spd_pkg::STAT_ZERO_SIZE;
              else state <= ST_SCAN;
            end
            spd_pkg::REQ_COMPACT: begin
              if (deleted != '0) begin
                if (slots_used <= deleted) begin
                  // every slot deleted: page back to its reset layout
                  slots_used <= '0;
                  data_end   <= HDR;
                  dir_start  <= PAGE;
                  deleted    <= '0;
                  wasted     <= '0;
                end else begin
                  state <= ST_SCAN;
                end
              end
            end
            spd_pkg::REQ_DELETE, spd_pkg::REQ_UPDATE, spd_pkg::REQ_FORWARD,
            spd_pkg::REQ_QUERY, spd_pkg::REQ_FOLLOW: begin
              if (req_r == spd_pkg::REQ_UPDATE && size_r == '0)
                r_status <= spd_pkg::STAT_ZERO_SIZE;
              else if ({1'b0, slot_r} >= slots_used)
                r_status <= spd_pkg::STAT_BAD_SLOT;
              else if (req_r == spd_pkg::REQ_FOLLOW) begin
                hop   <= '0;
                wpage <= own_page_id;
                wcur  <= slot_r;
                state <= ST_FRD;
              end else
                state <= ST_READ;
            end
            default: ;
          endcase
        end
        // one read issued and the previous entry checked every cycle
        ST_SCAN: begin
          chk <= 1'b0;
          if (req_r == spd_pkg::REQ_INSERT && chk && !rdata.live) begin
            reuse   <= 1'b1;
            pick    <= chk_idx;
            old_len <= rdata.len;
            state   <= ST_INS;
          end else begin
            if (req_r == spd_pkg::REQ_COMPACT && chk && rdata.live)
              pos <= pos + PW'(rdata.len);
            if (cnt < slots_used) begin
              chk     <= 1'b1;
              chk_idx <= cnt[7:0];
              cnt     <= cnt + 1'b1;
            end else if (!chk) begin
              if (req_r == spd_pkg::REQ_INSERT) begin
                pick  <= slots_used[7:0];
                state <= ST_INS;
              end else begin
                data_end <= pos;
                deleted  <= '0;
                wasted   <= '0;
                state    <= ST_FIN;
              end
            end
          end
        end
        ST_INS: begin
          if (!ins_ok) begin
            r_status <= spd_pkg::STAT_NO_SPACE;
          end else begin
            if (reuse) begin
              if (deleted != '0) deleted <= deleted - 1'b1;
              wasted <= (wasted >= PW'(old_len)) ? (wasted - PW'(old_len)) : '0;
            end else begin
              slots_used <= slots_used + 1'b1;
              dir_start  <= dir_start - ENT;
            end
            data_end <= data_end + PW'(size_r);
            r_slot   <= pick;
            r_ent    <= ins_ent;
          end
          state <= ST_FIN;
        end
        ST_READ: state <= ST_OP;
        ST_OP: begin
          r_status <= op_st;
          r_ent    <= op_ent;
          if (op_st == spd_pkg::STAT_OK) begin
            if (req_r == spd_pkg::REQ_DELETE) begin
              deleted <= deleted + 1'b1;
              wasted  <= wasted + PW'(rdata.len);
            end
            if (req_r == spd_pkg::REQ_FORWARD)
              wasted <= wasted + PW'(rdata.len);
            if (req_r == spd_pkg::REQ_QUERY && rdata.fwd) begin
              r_slot <= rdata.nslot;
              r_page <= rdata.npage;
            end
          end
          state <= ST_FIN;
        end
        // chain walk: leave the page, stop, or read the next hop
        ST_FRD: begin
          if (wpage != own_page_id) begin
            r_slot <= wcur;
            r_page <= wpage;
            state  <= ST_FIN;
          end else if ({1'b0, wcur} >= slots_used) begin
            r_status <= spd_pkg::STAT_CHAIN;
            state    <= ST_FIN;
          end else begin
            state <= ST_FCHK;
          end
        end
        ST_FCHK: begin
          if (hop == '0) r_ent <= rdata;
          state <= ST_FIN;
          if (!rdata.live) begin
            r_status <= spd_pkg::STAT_CHAIN;
          end else if (!rdata.fwd) begin
            r_slot <= wcur;
            r_page <= wpage;
          end else if (hop >= hop_limit) begin
            r_status <= spd_pkg::STAT_CHAIN;
          end else begin
            wpage <= rdata.npage;
            wcur  <= rdata.nslot;
            hop   <= hop + 1'b1;
            state <= ST_FRD;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            status           <= r_status;
            slot_out         <= r_slot;
            page_out         <= r_page;
            offset_out       <= r_ent.off[12:0];
            length_out       <= r_ent.len;
            valid_out        <= r_ent.live;
            forwarded_out    <= r_ent.fwd;
            free_bytes       <= free_now[13:0];
            needs_compaction <= flag;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: src/slotted_page_directory_unit.sv
// ---------------------------------------------------------------------------
// slotted_page_directory_unit
// Slot directory and free-space bookkeeping of one slotted page.
// ---------------------------------------------------------------------------
// One request is handled at a time. Delete, update, forward and query read,
// modify and write back their entry before the result is loaded; insert and
// compact scan the directory one memory read per cycle, over up to slots_used
// entries; a chain walk reads one entry per hop, up to hop_limit hops. The next
// request is taken in the cycle after the result is loaded. The single read
// port of the directory memory paces the scans and the chain walk.
// A finished result waits in the output register while the next request is
// taken, and the directory needs no clearing after reset.
module slotted_page_directory_unit #(
  parameter int PAGE_BYTES   = spd_pkg::PAGE_BYTES_DEF,
  parameter int HEADER_BYTES = spd_pkg::HEADER_BYTES_DEF,
  parameter int ENTRY_BYTES  = spd_pkg::ENTRY_BYTES_DEF,
  parameter int MAX_SLOTS    = spd_pkg::MAX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [7:0]  slot,
  input  logic [12:0] size,
  input  logic [15:0] target_page,
  input  logic [7:0]  target_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  slot_out,
  output logic [15:0] page_out,
  output logic [12:0] offset_out,
  output logic [12:0] length_out,
  output logic        valid_out,
  output logic        forwarded_out,
  output logic [13:0] free_bytes,
  output logic        needs_compaction
);

  logic [15:0]       own_page_id;
  logic [7:0]        hop_limit;
  spd_pkg::mem_req_t mreq;
  spd_pkg::entry_t   rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_page_id <= '0;
      hop_limit   <= 8'd4;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) own_page_id <= cfg_data;
      else hop_limit <= cfg_data[7:0];
    end
  end

  spd_table #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_table (
    .clk  (clk),
    .req  (mreq),
    .rdata(rdata)
  );

  spd_ctrl #(
    .PAGE_BYTES  (PAGE_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .ENTRY_BYTES (ENTRY_BYTES),
    .MAX_SLOTS   (MAX_SLOTS)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .slot            (slot),
    .size            (size),
    .target_page     (target_page),
    .target_slot     (target_slot),
    .own_page_id     (own_page_id),
    .hop_limit       (hop_limit),
    .mreq            (mreq),
    .rdata           (rdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .slot_out        (slot_out),
    .page_out        (page_out),
    .offset_out      (offset_out),
    .length_out      (length_out),
    .valid_out       (valid_out),
    .forwarded_out   (forwarded_out),
    .free_bytes      (free_bytes),
    .needs_compaction(needs_compaction)
  );

  // free space never exceeds the data area
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, free_bytes} <= 15'(PAGE_BYTES - HEADER_BYTES)))
    else $error("free space beyond page data area");

  // failed chain walk reports no final location
  a_chain_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == spd_pkg::STAT_CHAIN |-> page_out == '0 && slot_out == '0)
    else $error("chain failure with nonzero location");

  // bad slot addresses no entry
  a_bad_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == spd_pkg::STAT_BAD_SLOT |-> !valid_out && length_out == '0)
    else $error("bad slot result carries an entry");

endmodule

// File: verif/tb.sv
// ---------------------------------------------------------------------------
// slotted page directory testbench
// Drives directory requests through the valid/ready input channel and checks
// every result against a cycle-free predictor of the slot table, the free
// space and the compaction rule. It runs under several configurations,
// including random idling on both channels and one long output hold-off.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGE_SZ  = 8192;
  localparam int HDR_SZ   = 40;
  localparam int ENT_SZ   = 8;
  localparam int SLOT_CNT = 256;
  localparam logic [2:0] REQ_UNKNOWN = 3'd7;
  localparam logic CFG_PAGE_ID = 1'b0;
  localparam logic CFG_HOPS    = 1'b1;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  slot_out;
    logic [15:0] page_out;
    logic [12:0] offset_out;
    logic [12:0] length_out;
    logic        valid_out;
    logic        forwarded_out;
    logic [13:0] free_bytes;
    logic        needs_compaction;
  } dir_result_t;

  // expected directory behavior and result checking
  class directory_tracker;
    int ent_off[SLOT_CNT], ent_len[SLOT_CNT], ent_npage[SLOT_CNT], ent_nslot[SLOT_CNT];
    bit ent_live[SLOT_CNT], ent_fwd[SLOT_CNT];
    int data_end = HDR_SZ, dir_start = PAGE_SZ, n_used = 0, n_deleted = 0, wasted = 0;
    int page_id = 0, hop_limit = 4, fails = 0;
    dir_result_t pending_results[$];

    function void set_reg(logic idx, int val);
      if (idx == CFG_PAGE_ID) page_id = val & 16'hFFFF;
      else hop_limit = val & 8'hFF;
    endfunction

    function int free_space();
      return (dir_start >= data_end) ? dir_start - data_end : 0;
    endfunction

    function bit compact_wanted();
      int used, avail;
      if (n_deleted == 0) return 0;
      used = data_end - HDR_SZ;
      if (used > 0 && (wasted * 100) / used >= 50) return 1;
      if (n_deleted * 2 >= n_used) return 1;
      avail = free_space();
      return (avail < 100 && avail + wasted >= 100);
    endfunction

    function void fill_entry(ref dir_result_t r, input int s);
      r.offset_out    = ent_off[s][12:0];
      r.length_out    = ent_len[s][12:0];
      r.valid_out     = ent_live[s];
      r.forwarded_out = ent_fwd[s];
    endfunction

    // walk a forwarding chain, hands back status and final location
    function logic [2:0] walk_chain(int start, ref dir_result_t r);
      int hop, pg, cur;
      pg = page_id;
      cur = start;
      for (hop = 0; hop <= hop_limit; hop++) begin
        if (pg != page_id || (cur < n_used && ent_live[cur] && !ent_fwd[cur])) begin
          r.slot_out = cur[7:0];
          r.page_out = pg[15:0];
          return spd_pkg::STAT_OK;
        end
        if (cur >= n_used || !ent_live[cur] || hop >= hop_limit) return spd_pkg::STAT_CHAIN;
        pg = ent_npage[cur];
        cur = ent_nslot[cur];
      end
      return spd_pkg::STAT_CHAIN;
    endfunction

    function void compact_page();
      int i, pos;
      pos = HDR_SZ;
      if (n_deleted == 0) return;
      if (n_used <= n_deleted) begin
        n_used = 0;
        data_end = HDR_SZ;
        dir_start = PAGE_SZ;
      end else begin
        for (i = 0; i < n_used; i++) begin
          if (ent_live[i]) begin
            ent_off[i] = pos;
            pos += ent_len[i];
          end else begin
            ent_off[i] = 0; ent_len[i] = 0; ent_fwd[i] = 0;
            ent_npage[i] = 0; ent_nslot[i] = 0;
          end
        end
        data_end = pos;
      end
      n_deleted = 0;
      wasted = 0;
    endfunction

    function logic [2:0] insert_tuple(int sz, ref dir_result_t r);
      int i, pick, need;
      bit reuse;
      if (sz == 0) return spd_pkg::STAT_ZERO_SIZE;
      pick = n_used;
      reuse = 0;
      for (i = 0; i < n_used; i++)
        if (!ent_live[i]) begin
          pick = i;
          reuse = 1;
          break;
        end
      if (!reuse && n_used >= SLOT_CNT) return spd_pkg::STAT_NO_SPACE;
      need = reuse ? sz : sz + ENT_SZ;
      if (free_space() < need) return spd_pkg::STAT_NO_SPACE;
      if (reuse) begin
        if (n_deleted > 0) n_deleted--;
        wasted = (wasted >= ent_len[pick]) ? wasted - ent_len[pick] : 0;
      end else begin
        n_used++;
        dir_start -= ENT_SZ;
      end
      ent_off[pick] = data_end;
      ent_len[pick] = sz;
      ent_live[pick] = 1;
      ent_fwd[pick] = 0;
      ent_npage[pick] = 0;
      ent_nslot[pick] = 0;
      data_end += sz;
      r.slot_out = pick[7:0];
      fill_entry(r, pick);
      return spd_pkg::STAT_OK;
    endfunction

    // apply one accepted request and queue its expected result
    function void note_request(logic [2:0] rq, logic [7:0] sl, logic [12:0] sz,
                               logic [15:0] tp, logic [7:0] ts);
      dir_result_t r;
      logic [2:0] st;
      int s;
      bit in_range;
      r = '0;
      st = spd_pkg::STAT_OK;
      s = sl;
      in_range = s < n_used;
      case (rq)
        spd_pkg::REQ_INSERT: st = insert_tuple(sz, r);
        spd_pkg::REQ_DELETE: begin
          if (!in_range) st = spd_pkg::STAT_BAD_SLOT;
          else begin
            if (ent_live[s]) begin
              ent_live[s] = 0;
              n_deleted++;
              wasted += ent_len[s];
            end else st = spd_pkg::STAT_NOT_VALID;
            fill_entry(r, s);
          end
        end
        spd_pkg::REQ_UPDATE: begin
          if (sz == 0) st = spd_pkg::STAT_ZERO_SIZE;
          else if (!in_range) st = spd_pkg::STAT_BAD_SLOT;
          else begin
            if (!ent_live[s]) st = spd_pkg::STAT_NOT_VALID;
            else if (ent_fwd[s]) st = spd_pkg::STAT_FORWARDED;
            else if (sz > ent_len[s]) st = spd_pkg::STAT_TOO_LARGE;
            else ent_len[s] = sz;
            fill_entry(r, s);
          end
        end
        spd_pkg::REQ_FORWARD: begin
          if (!in_range) st = spd_pkg::STAT_BAD_SLOT;
          else begin
            if (ent_live[s]) begin
              wasted += ent_len[s];
              ent_len[s] = 0;
              ent_npage[s] = tp;
              ent_nslot[s] = ts;
              ent_fwd[s] = 1;
            end else st = spd_pkg::STAT_NOT_VALID;
            fill_entry(r, s);
          end
        end
        spd_pkg::REQ_FOLLOW: begin
          if (!in_range) st = spd_pkg::STAT_BAD_SLOT;
          else begin
            st = walk_chain(s, r);
            fill_entry(r, s);
          end
        end
        spd_pkg::REQ_COMPACT: compact_page();
        spd_pkg::REQ_QUERY: begin
          if (!in_range) st = spd_pkg::STAT_BAD_SLOT;
          else begin
            if (ent_fwd[s]) begin
              r.slot_out = ent_nslot[s][7:0];
              r.page_out = ent_npage[s][15:0];
            end
            fill_entry(r, s);
          end
        end
        default: ;
      endcase
      r.status = st;
      r.free_bytes = 14'(free_space());
      r.needs_compaction = compact_wanted();
      pending_results.insert(pending_results.size(), r);
    endfunction

    function void cmp_field(string name, int exp_v, int got_v);
      if (exp_v != got_v) begin
        $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
        fails++;
      end
    endfunction

    function void check_result(dir_result_t got);
      dir_result_t e;
      if (pending_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        fails++;
        return;
      end
      e = pending_results.pop_front();
      cmp_field("status", e.status, got.status);
      cmp_field("slot_out", e.slot_out, got.slot_out);
      cmp_field("page_out", e.page_out, got.page_out);
      cmp_field("offset_out", e.offset_out, got.offset_out);
      cmp_field("length_out", e.length_out, got.length_out);
      cmp_field("valid_out", e.valid_out, got.valid_out);
      cmp_field("forwarded_out", e.forwarded_out, got.forwarded_out);
      cmp_field("free_bytes", e.free_bytes, got.free_bytes);
      cmp_field("needs_compaction", e.needs_compaction, got.needs_compaction);
    endfunction
  endclass

  logic        clk = 0, rst = 1;
  logic        cfg_we = 0, cfg_index = 0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 0, in_ready;
  logic [2:0]  req_type = '0;
  logic [7:0]  slot = '0;
  logic [12:0] size = '0;
  logic [15:0] target_page = '0;
  logic [7:0]  target_slot = '0;
  logic        out_valid, out_ready = 0;
  logic [2:0]  status;
  logic [7:0]  slot_out;
  logic [15:0] page_out;
  logic [12:0] offset_out, length_out;
  logic        valid_out, forwarded_out;
  logic [13:0] free_bytes;
  logic        needs_compaction;

  directory_tracker dir_sb = new();
  bit quiet = 0, hold_now = 0;

  slotted_page_directory_unit DUT (.*);

  initial forever #5 clk = ~clk;

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  // transfer monitors
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      dir_sb.note_request(req_type, slot, size, target_page, target_slot);
    if (!rst && out_valid && out_ready)
      dir_sb.check_result({status, slot_out, page_out, offset_out, length_out,
                           valid_out, forwarded_out, free_bytes, needs_compaction});
  end

  // result side: random stalls plus one long hold-off
  initial forever begin
    if (hold_now) begin
      out_ready <= 0;
      repeat (400) @(posedge clk);
      hold_now = 0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      out_ready <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end else begin
      out_ready <= 1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic send_req(logic [2:0] rq, int sl, int sz, int tp, int ts);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1;
    req_type <= rq;
    slot <= 8'(sl);
    size <= 13'(sz);
    target_page <= 16'(tp);
    target_slot <= 8'(ts);
    do @(posedge clk); while (!in_ready);
  endtask

  // registers change only with nothing in flight
  task automatic set_regs(int page_id, int hops);
    in_valid <= 0;
    @(posedge clk);
    while (dir_sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= CFG_PAGE_ID;
    cfg_data <= 16'(page_id);
    dir_sb.set_reg(CFG_PAGE_ID, page_id);
    @(posedge clk);
    cfg_index <= CFG_HOPS;
    cfg_data <= 16'(hops);
    dir_sb.set_reg(CFG_HOPS, hops);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic rand_req();
    int r, u, sl, sz, tp, ts;
    logic [2:0] rq;
    u = dir_sb.n_used;
    r = $urandom_range(0, 99);
    sl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, u > 0 ? u - 1 : 0);
    if ($urandom_range(0, 3) == 0) begin
      tp = $urandom_range(0, 65535);
      ts = $urandom_range(0, 255);
    end else begin
      tp = dir_sb.page_id;
      ts = $urandom_range(0, u > 0 ? u : 0);
    end
    case ($urandom_range(0, 19))
      0: sz = 0;
      1: sz = $urandom_range(0, 8191);
      default: sz = $urandom_range(1, 48);
    endcase
    if (r < 30) rq = spd_pkg::REQ_INSERT;
    else if (r < 45) rq = spd_pkg::REQ_DELETE;
    else if (r < 55) rq = spd_pkg::REQ_UPDATE;
    else if (r < 67) rq = spd_pkg::REQ_FORWARD;
    else if (r < 82) rq = spd_pkg::REQ_FOLLOW;
    else if (r < 86) rq = spd_pkg::REQ_COMPACT;
    else if (r < 97) rq = spd_pkg::REQ_QUERY;
    else rq = REQ_UNKNOWN;
    send_req(rq, sl, sz, tp, ts);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    set_regs(0, 4);
    // directed corner cases
    send_req(spd_pkg::REQ_INSERT, 0, 0, 0, 0);
    send_req(spd_pkg::REQ_INSERT, 0, 8191, 0, 0);
    send_req(spd_pkg::REQ_QUERY, 0, 0, 0, 0);
    send_req(spd_pkg::REQ_INSERT, 0, 100, 0, 0);
    send_req(spd_pkg::REQ_INSERT, 0, 200, 0, 0);
    send_req(spd_pkg::REQ_UPDATE, 0, 0, 0, 0);
    send_req(spd_pkg::REQ_UPDATE, 0, 150, 0, 0);
    send_req(spd_pkg::REQ_UPDATE, 0, 50, 0, 0);
    send_req(spd_pkg::REQ_FORWARD, 1, 0, 0, 0);
    send_req(spd_pkg::REQ_FOLLOW, 1, 0, 0, 0);
    send_req(spd_pkg::REQ_QUERY, 1, 0, 0, 0);
    send_req(spd_pkg::REQ_UPDATE, 1, 10, 0, 0);
    send_req(spd_pkg::REQ_DELETE, 0, 0, 0, 0);
    send_req(spd_pkg::REQ_DELETE, 0, 0, 0, 0);
    send_req(spd_pkg::REQ_FOLLOW, 1, 0, 0, 0);
    send_req(spd_pkg::REQ_QUERY, 0, 0, 0, 0);
    send_req(spd_pkg::REQ_INSERT, 0, 30, 0, 0);
    send_req(spd_pkg::REQ_FORWARD, 0, 0, 16'hFFFF, 8'hFF);
    send_req(spd_pkg::REQ_FOLLOW, 0, 0, 0, 0);
    send_req(REQ_UNKNOWN, 8'hFF, 13'h1FFF, 16'hFFFF, 8'hFF);
    send_req(spd_pkg::REQ_COMPACT, 0, 0, 0, 0);
    send_req(spd_pkg::REQ_DELETE, 0, 0, 0, 0);
    send_req(spd_pkg::REQ_DELETE, 1, 0, 0, 0);
    send_req(spd_pkg::REQ_COMPACT, 0, 0, 0, 0);
    send_req(spd_pkg::REQ_DELETE, 255, 0, 0, 0);
    // fill the directory to its slot limit under a long output hold-off
    set_regs(16'hFFFF, 0);
    hold_now = 1;
    repeat (270) send_req(spd_pkg::REQ_INSERT, 0, $urandom_range(1, 8), 0, 0);
    repeat (120) rand_req();
    set_regs(0, 255);
    send_req(spd_pkg::REQ_COMPACT, 0, 0, 0, 0);
    repeat (150) rand_req();
    set_regs(16'h5A5A, 1);
    repeat (130) rand_req();
    set_regs(16'h00FF, 4);
    repeat (80) rand_req();
    quiet = 1;
    repeat (60) rand_req();
    in_valid <= 0;
    @(posedge clk);
    while (dir_sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (dir_sb.fails == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
